// ===== rtl/thc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants of the twelve-hour clock
// Field widths, register map codes and reset values of the clock block.
// ----------------------------------------------------------------------------
package thc_pkg;

    // field widths
    localparam int HOUR_W  = 4;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int TMR_W   = 10;
    localparam int RPT_W   = 3;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register map, word index taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_SLOW_MS    = 2'd0,
        REG_FAST_MS    = 2'd1,
        REG_SLOW_LIMIT = 2'd2
    } t_reg_idx;

    // reset values
    localparam logic [TMR_W-1:0] SLOW_MS_RST    = TMR_W'(500);
    localparam logic [TMR_W-1:0] FAST_MS_RST    = TMR_W'(100);
    localparam logic [RPT_W-1:0] SLOW_LIMIT_RST = RPT_W'(5);

    // counter limits
    localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
    localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
    localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(12);
    localparam logic [HOUR_W-1:0] HOUR_RST  = HOUR_W'(1);

endpackage

// ===== rtl/thc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_if: event and time channels of the twelve-hour clock
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface thc_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic minute_button;
    logic hour_button;

    modport source (output valid, mode, minute_button, hour_button, input ready);
    modport sink   (input valid, mode, minute_button, hour_button, output ready);
endinterface

interface thc_out_if
    import thc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] hour_value;
    logic [MIN_W-1:0]  minute_value;
    logic [SEC_W-1:0]  second_value;

    modport source (output valid, hour_value, minute_value, second_value, input ready);
    modport sink   (input valid, hour_value, minute_value, second_value, output ready);
endinterface

// ===== rtl/twelve_hour_clock_with_set_buttons.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twelve_hour_clock_with_set_buttons: HH:MM:SS clock with set buttons
// Counts one-second pulses into a 1..12 hour clock and serves the minute and
// hour set buttons with repeat timers driven by millisecond ticks.
// ----------------------------------------------------------------------------
//  channel   dir  port     contents
//  events    in   i_in     mode, minute_button, hour_button
//  time      out  o_out    hour_value, minute_value, second_value
//  config    in   APB      slow_repeat_ms @0x0, fast_repeat_ms @0x4,
//                          slow_repeat_limit @0x8
//
//  One cycle per word: the clock state is updated at the edge that accepts
//  an event and the updated time is shown on o_out from the next cycle.
//  The state registers double as the result register; a new word is taken
//  in the cycle that the previous result is taken, so words can go back to
//  back. A stalled o_out holds the time and stalls i_in.
//  Synchronous reset sets 00:00 at hour 1, timers ready, default config.
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_set_buttons
    import thc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    thc_in_if.sink            i_in,
    thc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [TMR_W-1:0]  r_slow_ms;
    logic [TMR_W-1:0]  r_fast_ms;
    logic [RPT_W-1:0]  r_slow_limit;

    logic [SEC_W-1:0]  r_sec,     n_sec;
    logic [MIN_W-1:0]  r_min,     n_min;
    logic [HOUR_W-1:0] r_hour,    n_hour;
    logic [TMR_W-1:0]  r_min_tmr, n_min_tmr;
    logic [TMR_W-1:0]  r_hr_tmr,  n_hr_tmr;
    logic [RPT_W-1:0]  r_rpt,     n_rpt;
    logic              r_out_valid;

    logic              acc;
    logic              cfg_wr;
    t_reg_idx          reg_idx;
    logic [TMR_W-1:0]  min_dec;
    logic [TMR_W-1:0]  hr_dec;

    function automatic logic [HOUR_W-1:0] next_hour(input logic [HOUR_W-1:0] h);
        if (h >= HOUR_LAST || h == '0) begin
            return HOUR_RST;
        end
        return h + HOUR_W'(1);
    endfunction

    // register access
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_SLOW_MS:    prdata = DATA_W'(r_slow_ms);
            REG_FAST_MS:    prdata = DATA_W'(r_fast_ms);
            REG_SLOW_LIMIT: prdata = DATA_W'(r_slow_limit);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_ms    <= SLOW_MS_RST;
            r_fast_ms    <= FAST_MS_RST;
            r_slow_limit <= SLOW_LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SLOW_MS:    r_slow_ms    <= pwdata[TMR_W-1:0];
                REG_FAST_MS:    r_fast_ms    <= pwdata[TMR_W-1:0];
                REG_SLOW_LIMIT: r_slow_limit <= pwdata[RPT_W-1:0];
                default:        ;
            endcase
        end
    end

    // handshake: take a word when the shown time is free or being taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;

    // count timers down, stopping at zero
    assign min_dec = (r_min_tmr != '0) ? r_min_tmr - TMR_W'(1) : '0;
    assign hr_dec  = (r_hr_tmr  != '0) ? r_hr_tmr  - TMR_W'(1) : '0;

    // advance the clock for one event
    always_comb begin
        n_sec     = r_sec;
        n_min     = r_min;
        n_hour    = r_hour;
        n_min_tmr = r_min_tmr;
        n_hr_tmr  = r_hr_tmr;
        n_rpt     = r_rpt;
        if (i_in.mode) begin
            // second pulse with carry into minutes and hours
            if (r_sec >= SEC_LAST) begin
                n_sec = '0;
                if (r_min >= MIN_LAST) begin
                    n_min  = '0;
                    n_hour = next_hour(r_hour);
                end else begin
                    n_min = r_min + MIN_W'(1);
                end
            end else begin
                n_sec = r_sec + SEC_W'(1);
            end
        end else begin
            n_min_tmr = min_dec;
            n_hr_tmr  = hr_dec;
            // minute button: clear seconds, advance minutes, re-arm
            if (min_dec == '0) begin
                if (i_in.minute_button) begin
                    n_sec = '0;
                    n_min = (r_min >= MIN_LAST) ? '0 : r_min + MIN_W'(1);
                    if (r_rpt < r_slow_limit) begin
                        n_rpt     = r_rpt + RPT_W'(1);
                        n_min_tmr = r_slow_ms;
                    end else begin
                        n_min_tmr = r_fast_ms;
                    end
                end else begin
                    n_rpt = '0;
                end
            end
            // hour button: advance hours, re-arm slow
            if (hr_dec == '0 && i_in.hour_button) begin
                n_hour   = next_hour(r_hour);
                n_hr_tmr = r_slow_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= HOUR_RST;
            r_min_tmr   <= '0;
            r_hr_tmr    <= '0;
            r_rpt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_sec     <= n_sec;
                r_min     <= n_min;
                r_hour    <= n_hour;
                r_min_tmr <= n_min_tmr;
                r_hr_tmr  <= n_hr_tmr;
                r_rpt     <= n_rpt;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // drive the time word
    assign o_out.valid        = r_out_valid;
    assign o_out.hour_value   = r_hour;
    assign o_out.minute_value = r_min;
    assign o_out.second_value = r_sec;

    // checks
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour >= HOUR_RST && r_hour <= HOUR_LAST))
        else $error("hour out of 1..12");

    a_acc_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted word not shown");

    a_sec_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.mode && r_sec < SEC_LAST) |=> (r_sec == $past(r_sec) + SEC_W'(1)))
        else $error("second pulse did not advance seconds");

    a_min_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_in.mode && i_in.minute_button && r_min_tmr <= TMR_W'(1))
        |=> (r_sec == '0 && (r_min_tmr == $past(r_slow_ms) || r_min_tmr == $past(r_fast_ms))))
        else $error("minute repeat did not re-arm");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> ($stable(r_min) && $stable(r_min_tmr)))
        else $error("clock state moved while time word stalled");

endmodule
